// ----- sv/h2r_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
package h2r_pkg;

	// Number format and hue scale.
	localparam int FRAC_BITS    = 12;
	localparam int HUE_SUBSTEPS = 16;
	localparam int SEC_W        = 60 * HUE_SUBSTEPS;
	localparam int HUE_LIMIT    = 6 * SEC_W;
	localparam int ONE          = 1 << FRAC_BITS;

	// Datapath widths.
	localparam int CH_W   = 13;
	localparam int WGT_W  = 10;
	localparam int SECT_W = 3;
	localparam int PROD_W = 2 * CH_W;
	localparam int P_W    = CH_W + WGT_W;

	// Division by the sector width of 960: a shift by 64, then a multiplication by
	// the rounded-up reciprocal of 15. The result is exact for every quotient that
	// an in-range pixel can produce.
	localparam int DIV_PRE_SHIFT = 6;
	localparam int DIV_SHIFT     = 20;
	localparam int DIV_RECIP     = 69906;
	localparam int RECIP_W       = 17;
	localparam int Q_W           = P_W - DIV_PRE_SHIFT;
	localparam int RM_W          = Q_W + RECIP_W;

	// Hue sectors, named by the colors at their two ends.
	localparam logic [SECT_W-1:0] SECT_RY = 3'd0;
	localparam logic [SECT_W-1:0] SECT_YG = 3'd1;
	localparam logic [SECT_W-1:0] SECT_GC = 3'd2;
	localparam logic [SECT_W-1:0] SECT_CB = 3'd3;
	localparam logic [SECT_W-1:0] SECT_BM = 3'd4;
	localparam logic [SECT_W-1:0] SECT_MR = 3'd5;

	// Input pixel.
	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_pix_t;

	// Output pixel.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            range_error;
	} rgb_pix_t;

	// Decoded hue and input check.
	typedef struct packed {
		logic              range_error;
		logic [SECT_W-1:0] sector;
		logic [WGT_W-1:0]  weight;
	} hue_dec_t;

endpackage

// ----- sv/h2r_hue_decode.sv -----
// Hue sector decode, weight of the second component, and input range check.
module h2r_hue_decode
	import h2r_pkg::*;
(
	input  logic [CH_W-1:0] hue,
	input  logic [CH_W-1:0] saturation,
	input  logic [CH_W-1:0] brightness,
	output hue_dec_t        dec
);

	logic [SECT_W-1:0] sector;
	logic [CH_W-1:0]   base;
	logic [CH_W-1:0]   offset;

	// Find the sector by comparing against its lower bound.
	always_comb begin
		priority if (hue >= CH_W'(5 * SEC_W)) begin
			sector = SECT_MR;
			base   = CH_W'(5 * SEC_W);
		end else if (hue >= CH_W'(4 * SEC_W)) begin
			sector = SECT_BM;
			base   = CH_W'(4 * SEC_W);
		end else if (hue >= CH_W'(3 * SEC_W)) begin
			sector = SECT_CB;
			base   = CH_W'(3 * SEC_W);
		end else if (hue >= CH_W'(2 * SEC_W)) begin
			sector = SECT_GC;
			base   = CH_W'(2 * SEC_W);
		end else if (hue >= CH_W'(SEC_W)) begin
			sector = SECT_YG;
			base   = CH_W'(SEC_W);
		end else begin
			sector = SECT_RY;
			base   = '0;
		end
	end

	assign offset = hue - base;

	// The weight rises across even sectors and falls across odd ones.
	always_comb begin
		dec.sector = sector;
		if (sector[0]) begin
			dec.weight = WGT_W'(SEC_W) - offset[WGT_W-1:0];
		end else begin
			dec.weight = offset[WGT_W-1:0];
		end
		dec.range_error = (hue >= CH_W'(HUE_LIMIT)) || (saturation > CH_W'(ONE)) ||
			(brightness > CH_W'(ONE));
	end

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter: four-stage pipeline with per-stage flow control.
// Throughput is one pixel per cycle while the output is not stalled; the chroma and
// weight multipliers and the reciprocal multiply each own a stage, and the last stage
// selects and offsets. A stalled output holds its pixel while empty stages upstream
// keep taking input. Reset clears all valid bits; the pipeline payload registers
// are not reset.
module hsv_to_rgb_converter
	import h2r_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     hsv_valid,
	output logic     hsv_stall,
	input  hsv_pix_t hsv,
	output logic     rgb_valid,
	input  logic     rgb_stall,
	output rgb_pix_t rgb
);

	hue_dec_t          dec;
	logic [PROD_W-1:0] prod;
	logic [P_W-1:0]    pw;
	logic [Q_W-1:0]    quo;
	logic [RM_W-1:0]   rm;
	logic [CH_W-1:0]   x_val;
	rgb_pix_t          rgb_next;

	logic rdy_1, rdy_2, rdy_3, rdy_out;
	logic vld_s1, vld_s2, vld_s3;
	logic rgb_vld_q;
	rgb_pix_t rgb_q;

	logic              err_s1, err_s2, err_s3;
	logic [SECT_W-1:0] sector_s1, sector_s2, sector_s3;
	logic [WGT_W-1:0]  w_s1;
	logic [CH_W-1:0]   c_s1, c_s2, c_s3;
	logic [CH_W-1:0]   v_s1, m_s2, m_s3;
	logic [P_W-1:0]    p_s2;
	logic [RM_W-1:0]   rm_s3;

	// A stage may load when it is empty or its contents move on.
	assign rdy_out   = !rgb_vld_q || !rgb_stall;
	assign rdy_3     = !vld_s3 || rdy_out;
	assign rdy_2     = !vld_s2 || rdy_3;
	assign rdy_1     = !vld_s1 || rdy_2;
	assign hsv_stall = !rdy_1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			rgb_vld_q <= 1'b0;
		end else begin
			if (rdy_1) begin
				vld_s1 <= hsv_valid;
			end
			if (rdy_2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				rgb_vld_q <= vld_s3;
			end
		end
	end

	// Stage 1: hue decode and chroma product.
	h2r_hue_decode u_hue_decode (
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.dec        (dec)
	);

	assign prod = PROD_W'(hsv.brightness) * PROD_W'(hsv.saturation);

	always_ff @(posedge clk) begin
		if (rdy_1) begin
			err_s1    <= dec.range_error;
			sector_s1 <= dec.sector;
			w_s1      <= dec.weight;
			c_s1      <= prod[FRAC_BITS +: CH_W];
			v_s1      <= hsv.brightness;
		end
	end

	// Stage 2: chroma times weight, and the offset.
	assign pw = P_W'(c_s1) * P_W'(w_s1);

	always_ff @(posedge clk) begin
		if (rdy_2) begin
			err_s2    <= err_s1;
			sector_s2 <= sector_s1;
			c_s2      <= c_s1;
			m_s2      <= v_s1 - c_s1;
			p_s2      <= pw;
		end
	end

	// Stage 3: divide by the sector width through the reciprocal.
	assign quo = p_s2[P_W-1:DIV_PRE_SHIFT];
	assign rm  = RM_W'(quo) * RM_W'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (rdy_3) begin
			err_s3    <= err_s2;
			sector_s3 <= sector_s2;
			c_s3      <= c_s2;
			m_s3      <= m_s2;
			rm_s3     <= rm;
		end
	end

	// Stage 4: place chroma and second component by sector, then add the offset.
	assign x_val = rm_s3[DIV_SHIFT +: CH_W];

	always_comb begin
		unique case (sector_s3)
			SECT_RY: begin
				rgb_next.red   = c_s3 + m_s3;
				rgb_next.green = x_val + m_s3;
				rgb_next.blue  = m_s3;
			end
			SECT_YG: begin
				rgb_next.red   = x_val + m_s3;
				rgb_next.green = c_s3 + m_s3;
				rgb_next.blue  = m_s3;
			end
			SECT_GC: begin
				rgb_next.red   = m_s3;
				rgb_next.green = c_s3 + m_s3;
				rgb_next.blue  = x_val + m_s3;
			end
			SECT_CB: begin
				rgb_next.red   = m_s3;
				rgb_next.green = x_val + m_s3;
				rgb_next.blue  = c_s3 + m_s3;
			end
			SECT_BM: begin
				rgb_next.red   = x_val + m_s3;
				rgb_next.green = m_s3;
				rgb_next.blue  = c_s3 + m_s3;
			end
			default: begin
				rgb_next.red   = c_s3 + m_s3;
				rgb_next.green = m_s3;
				rgb_next.blue  = x_val + m_s3;
			end
		endcase
		rgb_next.range_error = err_s3;
		if (err_s3) begin
			rgb_next.red   = '0;
			rgb_next.green = '0;
			rgb_next.blue  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			rgb_q <= rgb_next;
		end
	end

	assign rgb_valid = rgb_vld_q;
	assign rgb       = rgb_q;

	// An empty output register never stalls the input.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_vld_q |-> !hsv_stall)
		else $error("input stalled while output register empty");

	// A pixel leaving the last stage shows up at the output.
	a_stage3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && rdy_out |=> rgb_vld_q)
		else $error("pixel lost between last stage and output");

	// A flagged pixel carries black.
	a_error_black: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_vld_q && rgb_q.range_error |->
			rgb_q.red == '0 && rgb_q.green == '0 && rgb_q.blue == '0)
		else $error("range error with nonzero color");

	// An in-range pixel keeps its components within full scale.
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_vld_q && !rgb_q.range_error |->
			rgb_q.red <= CH_W'(ONE) && rgb_q.green <= CH_W'(ONE) &&
			rgb_q.blue <= CH_W'(ONE))
		else $error("color component above full scale");

	// Decoded sector and weight stay in bounds for in-range pixels.
	a_decode_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !err_s1 |-> sector_s1 <= SECT_MR && w_s1 <= WGT_W'(SEC_W))
		else $error("hue decode out of bounds");

endmodule
